// File: design/stf_pkg.sv
// Shared widths, action codes and the sine table builder for the sine tone generator.
package stf_pkg;

  localparam int unsigned FREQ_W     = 14;
  localparam int unsigned DUR_W      = 16;
  localparam int unsigned AMP_W      = 15;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned PHASE_W    = 32;
  localparam int unsigned DIVIDEND_W = FREQ_W + PHASE_W;
  localparam int unsigned DIVISOR_W  = 16;
  localparam int unsigned QUOT_W     = 32;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 24;

  localparam int unsigned SAMPLE_RATE_DEF     = 16000;
  localparam int unsigned FADE_LEN_DEF        = 32;
  localparam int unsigned SINE_TABLE_BITS_DEF = 10;

  localparam int unsigned MS_PER_S  = 1000;
  localparam logic [AMP_W-1:0] AMP_RESET = AMP_W'(2500);

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam int unsigned TAYLOR_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_STOP  = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  // Quarter-wave entry k of a table with 2^qbits steps, Q1.15, from a Q2.30 series.
  function automatic logic [15:0] qsin_entry(int unsigned k, int unsigned qbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    x    = (HALF_PI_Q30 * 64'(k)) >> qbits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int n = 0; n < 7; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n];
      if ((n % 2) == 0) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    v = (sum + 64'd16384) >> 15;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[15:0];
  endfunction

endpackage

// File: design/stf_div.sv
// Bit-serial restoring divider shared by the phase step, frame count and gain paths.
module stf_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             go,
  input  logic [stf_pkg::DIVIDEND_W-1:0]   dividend,
  input  logic [stf_pkg::DIVISOR_W-1:0]    divisor,
  output logic                             done,
  output logic [stf_pkg::QUOT_W-1:0]       quotient
);

  localparam int unsigned DVW   = stf_pkg::DIVIDEND_W;
  localparam int unsigned DSW   = stf_pkg::DIVISOR_W;
  localparam int unsigned QW    = stf_pkg::QUOT_W;
  localparam int unsigned CNT_W = $clog2(DVW);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVW-1:0]   dvd_r;
  logic [DSW-1:0]   dvs_r;
  logic [DSW-1:0]   rem_r;
  logic [QW-1:0]    quo_r;

  logic [DSW:0]     trial;
  logic             qbit;
  logic [DSW-1:0]   rem_nxt;

  always_comb begin
    trial   = {rem_r, dvd_r[DVW-1]};
    qbit    = (trial >= {1'b0, dvs_r});
    rem_nxt = qbit ? DSW'(trial - {1'b0, dvs_r}) : trial[DSW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !go && busy_r && (cnt_r == '0);
      if (go) begin
        dvd_r  <= dividend;
        dvs_r  <= divisor;
        rem_r  <= '0;
        cnt_r  <= CNT_W'(DVW - 1);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        // one quotient bit per cycle; high bits fall off the top (mod 2^32)
        rem_r <= rem_nxt;
        quo_r <= {quo_r[QW-2:0], qbit};
        dvd_r <= {dvd_r[DVW-2:0], 1'b0};
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: design/stf_sine.sv
// Quarter-wave sine lookup with quadrant folding and a registered read.
module stf_sine #(
  parameter int unsigned TABLE_BITS = stf_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic [stf_pkg::PHASE_W-1:0]   phase,
  output logic [stf_pkg::SAMPLE_W-1:0]  mag,
  output logic                          neg
);

  localparam int unsigned QTR_BITS = TABLE_BITS - 2;
  localparam int unsigned QTR      = 1 << QTR_BITS;
  localparam int unsigned PW       = stf_pkg::PHASE_W;

  logic [15:0] tab [QTR+1];

  for (genvar k = 0; k <= QTR; k++) begin : g_tab
    localparam logic [15:0] ENTRY = stf_pkg::qsin_entry(k, QTR_BITS);
    assign tab[k] = ENTRY;
  end

  logic [TABLE_BITS-1:0] idx;
  logic [1:0]            quad;
  logic [QTR_BITS-1:0]   pos;
  logic [QTR_BITS:0]     addr;

  always_comb begin
    idx  = phase[PW-1 -: TABLE_BITS];
    quad = idx[TABLE_BITS-1 -: 2];
    pos  = idx[QTR_BITS-1:0];
    // odd quadrants walk the table backward
    addr = quad[0] ? ((QTR_BITS+1)'(QTR) - {1'b0, pos}) : {1'b0, pos};
  end

  logic [stf_pkg::SAMPLE_W-1:0] mag_r;
  logic                         neg_r;

  always_ff @(posedge clk) begin
    mag_r <= stf_pkg::SAMPLE_W'(tab[addr]);
    neg_r <= quad[1];
  end

  assign mag = mag_r;
  assign neg = neg_r;

endmodule

// File: design/sine_tone_with_fade_top.sv
// Sine tone generator with linear fade, built around a shared bit-serial divider.
//
//  channel | ports                               | contents (lowest bit first)
//  --------+-------------------------------------+----------------------------------------
//  in      | in_tvalid in_tready in_tdata in_tuser | tdata: freq_hz[13:0] duration_ms[29:14]
//          |                                     | tuser: action[1:0]
//  out     | out_tvalid out_tready out_tdata out_tuser | tdata: sample[15:0] playing[16]
//          |                                     | tuser: frame_valid
//  cfg     | cfg_valid cfg_ready cfg_data        | amplitude[14:0]
//
// Stop, no-op, ignored starts and idle ticks pass from IDLE through PUSH to the output register.
// A tone frame runs MUL1, MUL2 and one division in GAIN; a start runs two divisions,
// STEP then FRAMES. The shared divider makes one quotient bit per cycle over the 46-bit dividend.
// One request is in flight at a time; a finished result waits in the output
// register and the next request is taken meanwhile. rst_n is synchronous.
module sine_tone_with_fade_top #(
  parameter int unsigned SAMPLE_RATE     = stf_pkg::SAMPLE_RATE_DEF,
  parameter int unsigned FADE_LEN        = stf_pkg::FADE_LEN_DEF,
  parameter int unsigned SINE_TABLE_BITS = stf_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [stf_pkg::IN_DATA_W-1:0]   in_tdata,   // freq_hz, duration_ms, zero pad
  input  logic [1:0]                      in_tuser,   // action
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [stf_pkg::OUT_DATA_W-1:0]  out_tdata,  // sample, playing, zero pad
  output logic [0:0]                      out_tuser,  // frame_valid
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [stf_pkg::AMP_W-1:0]       cfg_data    // amplitude
);

  localparam int unsigned FW     = stf_pkg::FREQ_W;
  localparam int unsigned DW     = stf_pkg::DUR_W;
  localparam int unsigned AW     = stf_pkg::AMP_W;
  localparam int unsigned SW     = stf_pkg::SAMPLE_W;
  localparam int unsigned PW     = stf_pkg::PHASE_W;
  localparam int unsigned DVW    = stf_pkg::DIVIDEND_W;
  localparam int unsigned DSW    = stf_pkg::DIVISOR_W;
  localparam int unsigned FT_W   = $clog2(longint'(65535) * SAMPLE_RATE / stf_pkg::MS_PER_S + 1);
  localparam int unsigned FADE_W = $clog2(FADE_LEN + 1);
  localparam int unsigned P1_W   = AW + SW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_FRAMES,
    ST_MUL1,
    ST_MUL2,
    ST_GAIN,
    ST_PUSH
  } state_t;

  state_t               state_r;
  logic [AW-1:0]        amp_r;
  logic [PW-1:0]        acc_r;
  logic [PW-1:0]        step_r;
  logic [FT_W-1:0]      total_r;
  logic [FT_W-1:0]      done_r;
  logic [FADE_W-1:0]    fade_r;
  logic                 active_r;
  logic [DW-1:0]        dur_r;
  logic [FADE_W-1:0]    gnum_r;
  logic [FADE_W-1:0]    gden_r;
  logic                 neg_r;
  logic [P1_W-1:0]      p1_r;
  logic [DVW-1:0]       dvd_r;
  logic [DSW-1:0]       dvs_r;
  logic                 go_r;
  logic [SW-1:0]        res_sample_r;
  logic                 res_frame_r;
  logic                 res_play_r;
  logic [SW-1:0]        out_sample_r;
  logic                 out_frame_r;
  logic                 out_play_r;
  logic                 out_tvalid_r;

  logic [FW-1:0]                  in_freq;
  logic [DW-1:0]                  in_dur;
  stf_pkg::action_t               in_action;
  logic                           in_req;
  logic                           start_ok;
  logic                           div_done;
  logic [stf_pkg::QUOT_W-1:0]     div_quo;
  logic [SW-1:0]                  sin_mag;
  logic                           sin_neg;

  logic [FT_W-1:0]      total_nxt;
  logic [FADE_W-1:0]    fade_nxt;
  logic [FT_W-1:0]      done_inc;
  logic [FT_W:0]        tail_sum;
  logic                 frame_ok;
  logic [FADE_W-1:0]    gnum_nxt;
  logic [FADE_W-1:0]    gden_nxt;
  logic [SW-1:0]        gain_q;
  logic [2*DW-1:0]      dur_prod;
  logic                 go_nxt;
  logic                 out_tvalid_nxt;

  assign in_freq   = in_tdata[FW-1:0];
  assign in_dur    = in_tdata[FW +: DW];
  assign in_action = stf_pkg::action_t'(in_tuser);
  assign in_tready = (state_r == ST_IDLE);
  assign in_req    = in_tvalid && in_tready;
  assign start_ok  = (in_freq != '0) && (in_dur != '0);
  assign cfg_ready = 1'b1;

  stf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (go_r),
    .dividend (dvd_r),
    .divisor  (dvs_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  stf_sine #(
    .TABLE_BITS (SINE_TABLE_BITS)
  ) u_sine (
    .clk   (clk),
    .phase (acc_r),
    .mag   (sin_mag),
    .neg   (sin_neg)
  );

  always_comb begin
    total_nxt = FT_W'(div_quo);
    fade_nxt  = (total_nxt < FT_W'(2 * FADE_LEN)) ? FADE_W'(total_nxt >> 1)
                                                   : FADE_W'(FADE_LEN);
    done_inc  = done_r + 1'b1;
    tail_sum  = {1'b0, done_r} + (FT_W+1)'(fade_r);
    frame_ok  = active_r && (done_r < total_r);
    gain_q    = div_quo[SW-1:0];
    dur_prod  = dur_r * DW'(SAMPLE_RATE);
    // launch a division on an accepted start, after the step, and for the gain
    go_nxt    = (in_req && in_action == stf_pkg::ACT_START && start_ok) ||
                (state_r == ST_STEP && div_done) || (state_r == ST_MUL2);
    // hold the result until it is taken
    out_tvalid_nxt = (state_r == ST_PUSH) || (out_tvalid_r && !out_tready);
    // fade-in, fade-out or full gain
    priority if (fade_r != '0 && done_r < FT_W'(fade_r)) begin
      gnum_nxt = FADE_W'(done_r);
      gden_nxt = fade_r;
    end else if (fade_r != '0 && tail_sum >= {1'b0, total_r}) begin
      gnum_nxt = FADE_W'(total_r - 1'b1 - done_r);
      gden_nxt = fade_r;
    end else begin
      gnum_nxt = FADE_W'(1);
      gden_nxt = FADE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      amp_r        <= stf_pkg::AMP_RESET;
      acc_r        <= '0;
      step_r       <= '0;
      total_r      <= '0;
      done_r       <= '0;
      fade_r       <= FADE_W'(FADE_LEN);
      active_r     <= 1'b0;
      go_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      go_r         <= go_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_valid && cfg_ready) begin
        amp_r <= cfg_data;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_req) begin
            res_sample_r <= '0;
            res_frame_r  <= 1'b0;
            unique case (in_action)
              stf_pkg::ACT_START: begin
                res_play_r <= active_r;
                if (start_ok) begin
                  dur_r   <= in_dur;
                  dvd_r   <= {in_freq, {PW{1'b0}}};
                  dvs_r   <= DSW'(SAMPLE_RATE);
                  state_r <= ST_STEP;
                end else begin
                  state_r <= ST_PUSH;
                end
              end
              stf_pkg::ACT_STOP: begin
                active_r   <= 1'b0;
                total_r    <= '0;
                done_r     <= '0;
                res_play_r <= 1'b0;
                state_r    <= ST_PUSH;
              end
              stf_pkg::ACT_TICK: begin
                if (frame_ok) begin
                  gnum_r  <= gnum_nxt;
                  gden_r  <= gden_nxt;
                  state_r <= ST_MUL1;
                end else begin
                  active_r   <= 1'b0;
                  res_play_r <= 1'b0;
                  state_r    <= ST_PUSH;
                end
              end
              stf_pkg::ACT_NOP: begin
                res_play_r <= active_r;
                state_r    <= ST_PUSH;
              end
              default: begin
                res_play_r <= active_r;
                state_r    <= ST_PUSH;
              end
            endcase
          end
        end
        ST_STEP: begin
          if (div_done) begin
            step_r  <= div_quo;
            dvd_r   <= DVW'(dur_prod);
            dvs_r   <= DSW'(stf_pkg::MS_PER_S);
            state_r <= ST_FRAMES;
          end
        end
        ST_FRAMES: begin
          if (div_done) begin
            acc_r      <= '0;
            total_r    <= total_nxt;
            done_r     <= '0;
            fade_r     <= fade_nxt;
            active_r   <= (total_nxt != '0);
            res_play_r <= (total_nxt != '0);
            state_r    <= ST_PUSH;
          end
        end
        ST_MUL1: begin
          p1_r    <= amp_r * sin_mag[AW-1:0] + P1_W'(0);
          neg_r   <= sin_neg;
          state_r <= ST_MUL2;
        end
        ST_MUL2: begin
          // drop the Q15 scale, then divide by the fade length (or by one at full gain)
          dvd_r   <= (DVW'(p1_r) * DVW'(gnum_r)) >> 15;
          dvs_r   <= DSW'(gden_r);
          state_r <= ST_GAIN;
        end
        ST_GAIN: begin
          if (div_done) begin
            res_sample_r <= neg_r ? (SW'(0) - gain_q) : gain_q;
            res_frame_r  <= 1'b1;
            res_play_r   <= (done_inc < total_r);
            active_r     <= (done_inc < total_r);
            acc_r        <= acc_r + step_r;
            done_r       <= done_inc;
            state_r      <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (!out_tvalid_r || out_tready) begin
            out_sample_r <= res_sample_r;
            out_frame_r  <= res_frame_r;
            out_play_r   <= res_play_r;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(stf_pkg::OUT_DATA_W - SW - 1){1'b0}}, out_play_r, out_sample_r};
  assign out_tuser  = out_frame_r;

endmodule

// File: verif/testbench.sv
// Self-checking stream testbench for the faded sine tone generator.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RATE      = stf_pkg::SAMPLE_RATE_DEF;
  localparam int unsigned FADE      = stf_pkg::FADE_LEN_DEF;
  localparam int unsigned TBITS     = stf_pkg::SINE_TABLE_BITS_DEF;
  localparam int unsigned QTR       = 1 << (TBITS - 2);
  localparam longint unsigned LIMIT = 1_500_000;
  localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;
  localparam int unsigned PHASE_ITEMS = 233;

  typedef struct {
    logic [15:0] sample;
    logic        frame_valid;
    logic        playing;
  } tone_frame_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [stf_pkg::IN_DATA_W-1:0]   in_tdata;
  logic [1:0]                      in_tuser;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [stf_pkg::OUT_DATA_W-1:0]  out_tdata;
  logic [0:0]                      out_tuser;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [stf_pkg::AMP_W-1:0]       cfg_data;

  // predictor state
  logic [15:0]  quarter_sine [0:QTR];
  logic [31:0]  phase;
  logic [31:0]  step;
  int unsigned  total_frames;
  int unsigned  done_frames;
  int unsigned  fade_span;
  logic         tone_on;
  logic [14:0]  amp_level;

  tone_frame_t     pending_frames[$];
  tone_frame_t     want;
  int unsigned     fail_count = 0;
  int unsigned     items_sent;
  int unsigned     burst_left;
  longint unsigned cycle_count = 0;

  // receiver stall pattern
  int unsigned stall_mode = 0;
  int unsigned stall_mode_left = 0;
  int unsigned pattern_cnt = 0;
  int unsigned hold_left = 0;
  logic        held_ready = 1'b1;
  logic        next_ready;

  sine_tone_with_fade_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [63:0] taylor_sine(logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int unsigned n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  function automatic void fill_sine_table();
    logic [63:0] x;
    logic [63:0] v;
    for (int unsigned k = 0; k <= QTR; k++) begin
      x = (QUARTER_TURN_Q30 * 64'(k)) / 64'(QTR);
      v = (taylor_sine(x) + 64'd16384) >> 15;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      quarter_sine[k] = v[15:0];
    end
  endfunction

  function automatic tone_frame_t next_tone_frame(stf_pkg::action_t act, logic [13:0] f,
                                                  logic [15:0] d);
    tone_frame_t r;
    logic [63:0] quot;
    logic [63:0] gnum;
    logic [63:0] gden;
    logic [63:0] mag;
    logic [63:0] res;
    logic [TBITS-1:0] idx;
    logic [1:0] quad;
    logic [TBITS-3:0] pos;
    logic [TBITS-2:0] addr;
    logic neg;
    r.sample      = 16'd0;
    r.frame_valid = 1'b0;
    case (act)
      stf_pkg::ACT_START: begin
        if (f != 0 && d != 0) begin
          quot         = {18'd0, f, 32'd0} / 64'(RATE);
          step         = quot[31:0];
          phase        = 32'd0;
          total_frames = int'((64'(d) * RATE) / stf_pkg::MS_PER_S);
          done_frames  = 0;
          fade_span    = (total_frames < 2 * FADE) ? total_frames / 2 : FADE;
          tone_on      = (total_frames != 0);
        end
      end
      stf_pkg::ACT_STOP: begin
        tone_on      = 1'b0;
        total_frames = 0;
        done_frames  = 0;
      end
      stf_pkg::ACT_TICK: begin
        if (tone_on && done_frames < total_frames) begin
          idx  = phase[31 -: TBITS];
          quad = idx[TBITS-1 -: 2];
          pos  = idx[TBITS-3:0];
          neg  = quad[1];
          addr = quad[0] ? ((TBITS-1)'(QTR) - {1'b0, pos}) : {1'b0, pos};
          mag  = 64'(quarter_sine[addr]);
          gnum = 64'd1;
          gden = 64'd1;
          if (fade_span != 0) begin
            if (done_frames < fade_span) begin
              gnum = 64'(done_frames);
              gden = 64'(fade_span);
            end else if (64'(done_frames) + fade_span >= 64'(total_frames)) begin
              gnum = 64'(total_frames - 1 - done_frames);
              gden = 64'(fade_span);
            end
          end
          res           = (64'(amp_level) * gnum * mag) / (gden * 64'd32768);
          r.sample      = neg ? 16'd0 - res[15:0] : res[15:0];
          r.frame_valid = 1'b1;
          phase         = phase + step;
          done_frames++;
          if (done_frames >= total_frames) begin
            tone_on = 1'b0;
          end
        end else begin
          tone_on = 1'b0;
        end
      end
      default: begin
      end
    endcase
    r.playing = tone_on;
    return r;
  endfunction

  // Send one request; bursts and gaps are decided here.
  task automatic send_item(stf_pkg::action_t act, logic [13:0] f, logic [15:0] d);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 5);
      burst_left = $urandom_range(1, 30);
      repeat (gap) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, d, f};
    in_tuser  <= act;
    do @(posedge clk); while (!in_tready);
    pending_frames.push_back(next_tone_frame(act, f, d));
    items_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(negedge clk);
  endtask

  task automatic write_amplitude(logic [14:0] v);
    drain_results();
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    amp_level = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_tone(logic [13:0] f, logic [15:0] d, int unsigned ticks);
    send_item(stf_pkg::ACT_START, f, d);
    repeat (ticks) begin
      send_item(stf_pkg::ACT_TICK, 14'($urandom_range(0, 16383)),
                16'($urandom_range(0, 65535)));
    end
  endtask

  task automatic test_idle_actions();
    send_item(stf_pkg::ACT_TICK, 14'h3FFF, 16'hFFFF);
    send_item(stf_pkg::ACT_NOP, 14'h3FFF, 16'hFFFF);
    send_item(stf_pkg::ACT_STOP, 14'd0, 16'd0);
    send_item(stf_pkg::ACT_START, 14'd0, 16'd7);
    send_item(stf_pkg::ACT_START, 14'd1234, 16'd0);
  endtask

  task automatic test_fade_and_restart();
    write_amplitude(15'h7FFF);
    // above the sample rate: the step wraps
    send_tone(14'h3FFF, 16'd1, 10);
    // restart mid-tone with the longest duration
    send_tone(14'd16000, 16'hFFFF, 2);
    send_tone(14'd1, 16'd2, 2);
    send_item(stf_pkg::ACT_STOP, 14'd0, 16'd0);
    send_item(stf_pkg::ACT_TICK, 14'd0, 16'd0);
  endtask

  task automatic test_random_phase(logic [14:0] amp, int unsigned n_items);
    int unsigned first;
    int unsigned sel;
    int unsigned ticks;
    logic [13:0] f;
    logic [15:0] d;
    write_amplitude(amp);
    first = items_sent;
    while (items_sent - first < n_items) begin
      sel = $urandom_range(0, 99);
      if (sel < 75) begin
        f = ($urandom_range(0, 3) == 0) ? 14'($urandom_range(0, 16383))
                                        : 14'($urandom_range(1, 8000));
        sel = $urandom_range(0, 9);
        if (sel < 7) begin
          d = 16'($urandom_range(1, 5));
        end else if (sel < 9) begin
          d = 16'($urandom_range(6, 12));
        end else begin
          d = 16'($urandom_range(0, 65535));
        end
        if (d == 0 || f == 0) begin
          ticks = $urandom_range(1, 4);
        end else if (d <= 12 && $urandom_range(0, 4) != 0) begin
          ticks = d * RATE / stf_pkg::MS_PER_S + $urandom_range(0, 3);
        end else begin
          ticks = $urandom_range(1, 60);
        end
        send_tone(f, d, ticks);
        if ($urandom_range(0, 2) == 0) begin
          send_item(stf_pkg::ACT_STOP, 14'($urandom_range(0, 16383)),
                    16'($urandom_range(0, 65535)));
        end
      end else if (sel < 97) begin
        repeat ($urandom_range(1, 6)) begin
          send_item(stf_pkg::action_t'($urandom_range(0, 3)), 14'($urandom_range(0, 16383)),
                    16'($urandom_range(0, 65535)));
        end
      end else begin
        // hold off until the pipeline is empty
        drain_results();
      end
    end
  endtask

  always @(negedge clk) begin
    if (stall_mode_left == 0) begin
      stall_mode      = $urandom_range(0, 3);
      stall_mode_left = $urandom_range(50, 400);
    end
    stall_mode_left--;
    pattern_cnt++;
    case (stall_mode)
      0: next_ready = 1'b1;
      1: next_ready = ($urandom_range(0, 9) >= 3);
      2: next_ready = ((pattern_cnt % 6) < 4);
      default: begin
        if (hold_left == 0) begin
          held_ready = ~held_ready;
          hold_left  = held_ready ? $urandom_range(1, 20) : $urandom_range(1, 40);
        end
        hold_left--;
        next_ready = held_ready;
      end
    endcase
    out_tready <= next_ready;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_frames.size() == 0) begin
        $error("unexpected result: sample %0d frame_valid %0b playing %0b",
               $signed(out_tdata[15:0]), out_tuser[0], out_tdata[16]);
        fail_count++;
      end else begin
        want = pending_frames.pop_front();
        if (out_tdata[15:0] !== want.sample) begin
          $error("sample: expected %0d actual %0d", $signed(want.sample),
                 $signed(out_tdata[15:0]));
          fail_count++;
        end
        if (out_tuser[0] !== want.frame_valid) begin
          $error("frame_valid: expected %0b actual %0b", want.frame_valid, out_tuser[0]);
          fail_count++;
        end
        if (out_tdata[16] !== want.playing) begin
          $error("playing: expected %0b actual %0b", want.playing, out_tdata[16]);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("sine_tone_with_fade_top regression: fail");
      $finish;
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    in_tuser        = '0;
    cfg_valid       = 1'b0;
    cfg_data        = '0;
    items_sent      = 0;
    burst_left      = 0;
    fill_sine_table();
    phase        = 32'd0;
    step         = 32'd0;
    total_frames = 0;
    done_frames  = 0;
    fade_span    = FADE;
    tone_on      = 1'b0;
    amp_level    = stf_pkg::AMP_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_actions();
    test_fade_and_restart();
    test_random_phase(15'd1, PHASE_ITEMS);
    test_random_phase(15'd0, PHASE_ITEMS);
    test_random_phase(15'h7FFF, PHASE_ITEMS);
    test_random_phase(15'($urandom_range(0, 32767)), PHASE_ITEMS);
    test_random_phase(15'($urandom_range(0, 32767)), PHASE_ITEMS);
    test_random_phase(stf_pkg::AMP_RESET, PHASE_ITEMS);

    drain_results();
    repeat (120) @(posedge clk);
    if (fail_count == 0) begin
      $display("sine_tone_with_fade_top regression: pass");
    end else begin
      $display("sine_tone_with_fade_top regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
design/stf_pkg.sv
design/stf_div.sv
design/stf_sine.sv
design/sine_tone_with_fade_top.sv
verif/testbench.sv
